// ===== rtl/core/efu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efu_pkg: shared types and constants for the escaped frame unstuffer
// Holds the input and result item structs, the byte codes of the escape
// scheme and the bundle that carries one item's worth of results.
// ----------------------------------------------------------------------------
package efu_pkg;

  localparam logic [7:0] ESC_BYTE      = 8'h7D;
  localparam logic [7:0] ESC_FLAG_CODE = 8'h02;
  localparam logic [7:0] ESC_SELF_CODE = 8'h01;
  localparam logic [7:0] FLAG_BYTE     = 8'h7E;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_start;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       is_checksum;
    logic       check_ok;
  } out_t;

  // Up to two results caused by one input byte; count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    out_t       first;
    out_t       second;
  } pair_t;

endpackage

// ===== rtl/core/escaped_frame_unstuff_xor_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_frame_unstuff_xor_check: byte unstuffing with XOR checksum check
// Path: input register, then result register; a stall can hold either.
// Throughput: one input byte per cycle while the output takes each result; a
// byte with two results holds the output for both, so the output sets the rate.
// Reset: synchronous, active high; clears the frame state and empties both
// the input register and the result register.
// ----------------------------------------------------------------------------
module escaped_frame_unstuff_xor_check (
  input  logic          clk,
  input  logic          rst,
  input  logic          frame_valid,
  output logic          frame_ready,
  input  efu_pkg::in_t  frame,
  output logic          restored_valid,
  input  logic          restored_ready,
  output efu_pkg::out_t restored
);
  import efu_pkg::*;

  // Input register: one received byte waiting to be unstuffed.
  logic  in_full;
  in_t   in_item;

  // Result register: the results of one byte, shown one per transfer.
  logic [1:0] res_count;
  logic       res_sel;
  out_t       res_first;
  out_t       res_second;

  pair_t results;
  logic  res_pop;
  logic  res_load_ok;
  logic  advance;

  // The unstuffer works on the held byte; its state moves only when the
  // byte's results are taken into the result register.
  efu_unstuff u_unstuff (
    .clk     (clk),
    .rst     (rst),
    .item    (in_item),
    .advance (advance),
    .results (results)
  );

  assign restored_valid = (res_count != 2'd0);
  assign restored       = res_sel ? res_second : res_first;
  assign res_pop        = restored_valid && restored_ready;

  // The result register can take a new pair when it is empty or when its
  // last pending result leaves in this cycle.
  assign res_load_ok = (res_count == 2'd0) || ((res_count == 2'd1) && restored_ready);
  assign advance     = in_full && res_load_ok;
  assign frame_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (frame_ready) begin
      in_full <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && frame_ready) begin
      in_item <= frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_count <= 2'd0;
      res_sel   <= 1'b0;
    end else if (advance) begin
      // A byte that only holds back an escape loads a count of zero.
      res_count <= results.count;
      res_sel   <= 1'b0;
    end else if (res_pop) begin
      res_count <= res_count - 2'd1;
      res_sel   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_first  <= results.first;
      res_second <= results.second;
    end
  end

endmodule

// ===== rtl/core/efu_unstuff.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efu_unstuff: escape removal and XOR checksum tracking
// Turns one received byte into zero, one or two restored bytes and keeps
// the per-frame state, which advances when the caller takes the results.
// ----------------------------------------------------------------------------
module efu_unstuff (
  input  logic          clk,
  input  logic          rst,
  input  efu_pkg::in_t  item,
  input  logic          advance,
  output efu_pkg::pair_t results
);
  import efu_pkg::*;

  logic       escape_pending;
  logic [7:0] xor_accum;
  logic [1:0] restored_count;

  logic       escape_pending_next;
  logic [7:0] xor_accum_next;
  logic [1:0] restored_count_next;

  logic [7:0] base_accum;
  logic [1:0] base_count;
  logic [7:0] got0;
  logic [7:0] got1;
  logic [1:0] n;
  logic       pend;
  logic       ck0;
  logic [7:0] accum1;
  logic [7:0] accum2;
  logic [1:0] count1;
  logic [1:0] count2;

  always_comb begin
    got0 = item.in_byte;
    got1 = item.in_byte;
    n    = 2'd0;
    pend = 1'b0;
    if (item.frame_start) begin
      n = 2'd1;
    end else if (escape_pending) begin
      if (item.in_byte == ESC_FLAG_CODE) begin
        got0 = FLAG_BYTE;
        n    = 2'd1;
      end else if (item.in_byte == ESC_SELF_CODE) begin
        got0 = ESC_BYTE;
        n    = 2'd1;
      end else if (item.in_byte == ESC_BYTE) begin
        got0 = ESC_BYTE;
        n    = 2'd1;
        pend = 1'b1;
      end else begin
        got0 = ESC_BYTE;
        n    = 2'd2;
      end
    end else if (item.in_byte == ESC_BYTE) begin
      pend = 1'b1;
    end else begin
      n = 2'd1;
    end

    // A held escape byte still open at the frame end is emitted literally.
    if (item.frame_end && pend) begin
      pend = 1'b0;
      if (n == 2'd0) begin
        got0 = ESC_BYTE;
        n    = 2'd1;
      end else begin
        got1 = ESC_BYTE;
        n    = 2'd2;
      end
    end
  end

  always_comb begin
    base_accum = item.frame_start ? 8'h00 : xor_accum;
    base_count = item.frame_start ? 2'd0 : restored_count;

    ck0    = item.frame_end && (n == 2'd1);
    accum1 = base_accum ^ got0;
    count1 = (base_count == 2'd2) ? 2'd2 : base_count + 2'd1;
    accum2 = accum1 ^ got1;
    count2 = (count1 == 2'd2) ? 2'd2 : count1 + 2'd1;

    results.count                = n;
    results.first.out_byte       = got0;
    results.first.run_last       = (n == 2'd1);
    results.first.is_checksum    = ck0;
    results.first.check_ok       = ck0 && (base_count != 2'd0) && (got0 == base_accum);
    results.second.out_byte      = got1;
    results.second.run_last      = 1'b1;
    results.second.is_checksum   = item.frame_end;
    results.second.check_ok      = item.frame_end && (got1 == accum1);

    escape_pending_next = pend;
    xor_accum_next      = base_accum;
    restored_count_next = base_count;
    if (item.frame_end) begin
      escape_pending_next = 1'b0;
      xor_accum_next      = 8'h00;
      restored_count_next = 2'd0;
    end else if (n == 2'd1) begin
      xor_accum_next      = accum1;
      restored_count_next = count1;
    end else if (n == 2'd2) begin
      xor_accum_next      = accum2;
      restored_count_next = count2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      xor_accum      <= 8'h00;
      restored_count <= 2'd0;
    end else if (advance) begin
      escape_pending <= escape_pending_next;
      xor_accum      <= xor_accum_next;
      restored_count <= restored_count_next;
    end
  end

endmodule
